[design/spt_pkg.sv]
`timescale 1ns / 1ps

package spt_pkg;

    // Port widths
    localparam int ADC_W  = 24;
    localparam int KW     = 16;
    localparam int TW     = 16;
    localparam int CFG_IW = 3;

    // Calibration register indexes
    localparam logic [CFG_IW-1:0] CFG_K4 = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_K3 = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_K2 = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_K1 = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_K0 = 3'd4;

    // Scaled coefficient widths: c3 = 8*k3*S, c2 = 4*k2*S^2, c1 = 2*k1*S^3, c0 = 3e4*k0*S^3
    localparam int C3W = 36;
    localparam int C2W = 52;
    localparam int C1W = 67;
    localparam int C0W = 85;

    localparam logic [16:0] SCALE  = 17'd100000;
    localparam logic [18:0] C0_MUL = 19'd30000;

    // Partial product chunk width of the wide multiplier
    localparam int MUL_CW = 24;

    // Divider: quotient bits, remainder width, denominator 2e19, limit 32768 * 2e19
    localparam int          QW  = 16;
    localparam int          RW  = 80;
    localparam logic [64:0] DEN = 65'd20000000000000000000;
    localparam logic [79:0] LIM = 80'd655360000000000000000000;

    localparam logic signed [TW-1:0] TEMP_MAX = 16'sh7FFF;
    localparam logic signed [TW-1:0] TEMP_MIN = 16'sh8000;

    typedef struct packed {
        logic [KW-1:0]  k4;
        logic [C3W-1:0] c3;
        logic [C2W-1:0] c2;
        logic [C1W-1:0] c1;
        logic [C0W-1:0] c0;
    } t_coef;

endpackage

[design/sensor_poly_temperature.sv]
`timescale 1ns / 1ps

// Fourth-order polynomial linearization of a raw temperature conversion. Each
// item is a 24-bit conversion result; its upper bits (ADC_SHIFT dropped) form
// the code a, and the block returns floor(100*T) in 0.01 degC, saturated to a
// signed 16-bit count, with o_clipped set whenever saturation took place. The
// evaluation is exact integer arithmetic with no rounding anywhere. One item
// is accepted every clock while o_stall is low; its result passes through the
// pipeline: three Horner multiply steps of two stages each (24-bit partial
// products, then their sum) and a restoring divide by 2e19 that retires one
// quotient bit per stage. A result waiting at the output does not block
// input: a skid entry takes the next one, and o_stall rises only when both
// are full. Calibration words must be written through the plain write port
// only while the block is idle; the block itself does not enforce this. The
// scaled coefficients derived from them settle through a chain of registers.
module sensor_poly_temperature #(
    parameter int ADC_SHIFT = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [spt_pkg::ADC_W-1:0]      i_adc_raw,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [spt_pkg::TW-1:0]  o_temp_centi,
    output logic                           o_clipped,
    input  logic                           i_cfg_we,
    input  logic [spt_pkg::CFG_IW-1:0]     i_cfg_idx,
    input  logic [spt_pkg::KW-1:0]         i_cfg_data
);
    import spt_pkg::*;

    // Width of the code a and of each Horner partial value (signed, with margin)
    localparam int AW = ADC_W - ADC_SHIFT;
    localparam int W1 = ((AW + 20) > 38) ? (AW + 20) : 38;
    localparam int W2 = ((W1 + AW + 1) > 54) ? (W1 + AW + 1) : 54;
    localparam int W3 = ((W2 + AW + 1) > 69) ? (W2 + AW + 1) : 69;
    localparam int W4 = ((W3 + AW + 1) > 87) ? (W3 + AW + 1) : 87;

    t_coef                w_coef;
    logic                 w_hold;
    logic                 w_en;

    logic                 r_va, r_vb, r_vc;
    logic [AW-1:0]        r_a, r_ab, r_ac;
    logic [KW+AW-1:0]     r_m1;
    logic signed [W1-1:0] r_p1;

    logic signed [W2-1:0] w_add2;
    logic signed [W3-1:0] w_add3;
    logic signed [W4-1:0] w_add4;

    logic                 w_v2, w_v3, w_v4;
    logic signed [W2-1:0] w_p2;
    logic signed [W3-1:0] w_p3;
    logic signed [W4-1:0] w_p4;
    logic [AW-1:0]        w_a2, w_a3;

    spt_coef u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coef     (w_coef)
    );

    // Stall only when the output skid entry is occupied; all stages move together
    assign w_en    = ~w_hold;
    assign o_stall = w_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (w_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    // The numerator is scaled so every term is an integer over 2e19:
    //   4M = (((C3 - 4*k4*a)*a - C2)*a + C1)*a - C0
    // Capture a, form k4*a, then start the Horner chain with C3 - 4*k4*a.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a  <= i_adc_raw[ADC_W-1:ADC_SHIFT];
            r_m1 <= (KW + AW)'(w_coef.k4) * (KW + AW)'(r_a);
            r_ab <= r_a;
            r_p1 <= $signed(W1'(w_coef.c3)) - $signed(W1'({r_m1, 2'b00}));
            r_ac <= r_ab;
        end
    end

    // Coefficients added in each Horner step, with their signs
    assign w_add2 = -$signed(W2'(w_coef.c2));
    assign w_add3 = $signed(W3'(w_coef.c1));
    assign w_add4 = -$signed(W4'(w_coef.c0));

    spt_mulw #(.AW(AW), .WI(W1), .WO(W2)) u_mul2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vc),
        .i_x     (r_p1),
        .i_a     (r_ac),
        .i_add   (w_add2),
        .o_valid (w_v2),
        .o_y     (w_p2),
        .o_a     (w_a2)
    );

    spt_mulw #(.AW(AW), .WI(W2), .WO(W3)) u_mul3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v2),
        .i_x     (w_p2),
        .i_a     (w_a2),
        .i_add   (w_add3),
        .o_valid (w_v3),
        .o_y     (w_p3),
        .o_a     (w_a3)
    );

    // Last step: a is no longer needed after this multiply
    spt_mulw #(.AW(AW), .WI(W3), .WO(W4)) u_mul4 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v3),
        .i_x     (w_p3),
        .i_a     (w_a3),
        .i_add   (w_add4),
        .o_valid (w_v4),
        .o_y     (w_p4),
        .o_a     ()
    );

    // Floor divide by 2e19, saturate, and hold the result for the consumer
    spt_div #(.WN(W4)) u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_v4),
        .i_num        (w_p4),
        .o_hold       (w_hold),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_temp_centi (o_temp_centi),
        .o_clipped    (o_clipped)
    );

endmodule

[design/spt_coef.sv]
`timescale 1ns / 1ps

module spt_coef (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [spt_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [spt_pkg::KW-1:0]     i_cfg_data,
    output spt_pkg::t_coef            o_coef
);
    import spt_pkg::*;

    logic [KW-1:0]  r_k4, r_k3, r_k2, r_k1, r_k0;
    logic [32:0]    r_k2s, r_k1s, r_k0s;
    logic [49:0]    r_k1s2, r_k0s2;
    logic [65:0]    r_k0s3;
    logic [C3W-1:0] r_c3;
    logic [C2W-1:0] r_c2;
    logic [C1W-1:0] r_c1;
    logic [C0W-1:0] r_c0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k4   <= '0;
            r_k3   <= '0;
            r_k2   <= '0;
            r_k1   <= '0;
            r_k0   <= '0;
            r_k2s  <= '0;
            r_k1s  <= '0;
            r_k0s  <= '0;
            r_k1s2 <= '0;
            r_k0s2 <= '0;
            r_k0s3 <= '0;
            r_c3   <= '0;
            r_c2   <= '0;
            r_c1   <= '0;
            r_c0   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_K4:  r_k4 <= i_cfg_data;
                    CFG_K3:  r_k3 <= i_cfg_data;
                    CFG_K2:  r_k2 <= i_cfg_data;
                    CFG_K1:  r_k1 <= i_cfg_data;
                    CFG_K0:  r_k0 <= i_cfg_data;
                    default: ;
                endcase
            end
            // One power of the scale per cycle; c0 settles last, through r_k0s, r_k0s2 and r_k0s3
            r_c3   <= {33'(r_k3) * 33'(SCALE), 3'b000};
            r_k2s  <= 33'(r_k2) * 33'(SCALE);
            r_c2   <= {50'(r_k2s) * 50'(SCALE), 2'b00};
            r_k1s  <= 33'(r_k1) * 33'(SCALE);
            r_k1s2 <= 50'(r_k1s) * 50'(SCALE);
            r_c1   <= {66'(r_k1s2) * 66'(SCALE), 1'b0};
            r_k0s  <= 33'(r_k0) * 33'(SCALE);
            r_k0s2 <= 50'(r_k0s) * 50'(SCALE);
            r_k0s3 <= 66'(r_k0s2) * 66'(SCALE);
            r_c0   <= 85'(r_k0s3) * 85'(C0_MUL);
        end
    end

    assign o_coef.k4 = r_k4;
    assign o_coef.c3 = r_c3;
    assign o_coef.c2 = r_c2;
    assign o_coef.c1 = r_c1;
    assign o_coef.c0 = r_c0;

endmodule

[design/spt_mulw.sv]
`timescale 1ns / 1ps

module spt_mulw #(
    parameter int AW = 16,
    parameter int WI = 38,
    parameter int WO = 55
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [WI-1:0] i_x,
    input  logic [AW-1:0]        i_a,
    input  logic signed [WO-1:0] i_add,
    output logic                 o_valid,
    output logic signed [WO-1:0] o_y,
    output logic [AW-1:0]        o_a
);
    import spt_pkg::*;

    localparam int NC = (WI + MUL_CW - 1) / MUL_CW;
    localparam int XW = NC * MUL_CW;
    localparam int PW = MUL_CW + AW + 1;

    logic signed [XW-1:0]     w_xe;
    logic signed [MUL_CW:0]   w_xs [NC];
    logic signed [PW-1:0]     n_pp [NC];
    logic signed [PW-1:0]     r_pp [NC];
    logic signed [WO-1:0]     n_y;
    logic signed [WO-1:0]     r_y;
    logic [AW-1:0]            r_a1, r_a2;
    logic                     r_v1, r_v2;

    assign w_xe = XW'(i_x);

    // Low chunks are unsigned, the top chunk carries the sign
    always_comb begin
        for (int j = 0; j < NC; j++) begin
            if (j == NC - 1) begin
                w_xs[j] = {w_xe[XW-1], w_xe[j*MUL_CW +: MUL_CW]};
            end else begin
                w_xs[j] = {1'b0, w_xe[j*MUL_CW +: MUL_CW]};
            end
            n_pp[j] = PW'(w_xs[j]) * PW'($signed({1'b0, i_a}));
        end
    end

    // Sum the shifted partial products together with the coefficient
    always_comb begin
        n_y = i_add;
        for (int j = 0; j < NC; j++) begin
            n_y = n_y + (WO'(r_pp[j]) <<< (j * MUL_CW));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp <= n_pp;
            r_a1 <= i_a;
            r_y  <= n_y;
            r_a2 <= r_a1;
        end
    end

    assign o_valid = r_v2;
    assign o_y     = r_y;
    assign o_a     = r_a2;

endmodule

[design/spt_div.sv]
`timescale 1ns / 1ps

module spt_div #(
    parameter int WN = 119
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic signed [WN-1:0]        i_num,
    output logic                        o_hold,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [spt_pkg::TW-1:0] o_temp_centi,
    output logic                        o_clipped
);
    import spt_pkg::*;

    localparam int NS  = QW + 3;
    localparam int FMT = QW + 2;
    localparam int CMW = (WN > RW) ? WN : RW;

    logic [NS-1:0]        r_v;
    logic                 w_en;
    logic                 w_ofree;

    logic [WN-1:0]        r_mag0;
    logic                 r_neg0;
    logic [RW-1:0]        r_rem   [QW+1];
    logic [QW-1:0]        r_q     [QW+1];
    logic                 r_negs  [QW+1];
    logic                 r_clips [QW+1];

    logic                 w_inexact;
    logic [QW-1:0]        w_qq;
    logic signed [TW-1:0] r_fres;
    logic                 r_fclip;

    logic                 r_ov, r_sv;
    logic signed [TW-1:0] r_ot, r_st;
    logic                 r_oc, r_sc;

    // The whole pipe advances unless the skid register holds an item
    assign w_en    = ~r_sv;
    assign w_ofree = ~r_ov | ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    // Sign and magnitude, then range check against 32768 * 2e19
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg0     <= i_num[WN-1];
            r_mag0     <= i_num[WN-1] ? $unsigned(-i_num) : $unsigned(i_num);
            r_negs[0]  <= r_neg0;
            r_clips[0] <= r_neg0 ? (CMW'(r_mag0) >  CMW'(LIM))
                                 : (CMW'(r_mag0) >= CMW'(LIM));
            r_rem[0]   <= RW'(r_mag0);
            r_q[0]     <= '0;
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_bit
        localparam int B = QW - 1 - k;
        logic [RW:0] w_trial;

        assign w_trial = {1'b0, r_rem[k]} - ((RW + 1)'(DEN) << B);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[k+1]   <= w_trial[RW] ? r_rem[k] : w_trial[RW-1:0];
                r_q[k+1]     <= w_trial[RW] ? r_q[k] : (r_q[k] | (QW'(1) << B));
                r_negs[k+1]  <= r_negs[k];
                r_clips[k+1] <= r_clips[k];
            end
        end
    end

    // Floor of a negative value rounds the magnitude up
    assign w_inexact = |r_rem[QW];
    assign w_qq      = r_q[QW] + QW'(w_inexact);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fclip <= r_clips[QW];
            if (r_clips[QW]) begin
                r_fres <= r_negs[QW] ? TEMP_MIN : TEMP_MAX;
            end else if (r_negs[QW]) begin
                r_fres <= $signed(TW'(QW'(0) - w_qq));
            end else begin
                r_fres <= $signed(TW'(r_q[QW]));
            end
        end
    end

    // Output register with a skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_ofree) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end
        end else if (w_ofree) begin
            r_ov <= r_v[FMT];
        end else if (r_v[FMT]) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (w_ofree) begin
                r_ot <= r_st;
                r_oc <= r_sc;
            end
        end else if (w_ofree) begin
            r_ot <= r_fres;
            r_oc <= r_fclip;
        end else begin
            r_st <= r_fres;
            r_sc <= r_fclip;
        end
    end

    assign o_hold       = r_sv;
    assign o_valid      = r_ov;
    assign o_temp_centi = r_ot;
    assign o_clipped    = r_oc;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry held without a valid output item");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv && !i_stall |=> !r_sv)
        else $error("skid entry not drained after output was taken");

    a_pos_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[QW+1] && !r_clips[QW] && !r_negs[QW] |-> !r_q[QW][QW-1])
        else $error("positive quotient exceeds output range without clip");

    a_neg_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[QW+1] && !r_clips[QW] && r_negs[QW] && r_q[QW][QW-1]
            |-> (r_q[QW][QW-2:0] == '0) && (r_rem[QW] == '0))
        else $error("negative quotient exceeds output range without clip");

endmodule

[dv/tb_sensor_poly_temperature.sv]
`timescale 1ns / 1ps

module tb_sensor_poly_temperature;
    import spt_pkg::*;

    localparam int ADC_SHIFT   = 8;
    // Longest run of cycles with no item moving on either channel before the run is abandoned.
    // Covers the pipeline depth, a calibration pause and long random stall streaks.
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_TAIL  = 40;
    localparam int BLOCKS      = 12;
    localparam int BLOCK_ITEMS = 160;

    // First register index that maps to no calibration word.
    localparam logic [CFG_IW-1:0] CFG_SPARE = CFG_K0 + 3'd1;

    typedef logic [KW-1:0] cal_words_t [5];

    // Expected readings for each accepted conversion, computed from the calibration words.
    class temp_checker;
        typedef struct {
            logic signed [TW-1:0] centi;
            logic                 clipped;
        } reading_t;

        logic [KW-1:0] cal [5];
        reading_t      readings_q [$];
        int            errors;

        function new();
            foreach (cal[i]) cal[i] = '0;
            errors = 0;
        endfunction

        function void write_cal(logic [CFG_IW-1:0] idx, logic [KW-1:0] data);
            // Indexes past the last word hit nothing.
            if (idx <= CFG_K0) cal[idx] = data;
        endfunction

        // Evaluate floor(100*T) exactly: the numerator is kept over a denominator of 2e20.
        function void note_conversion(logic [ADC_W-1:0] raw);
            logic [127:0] code, pos, neg, mag, quo, rem;
            logic [127:0] den;
            reading_t     exp_r;
            den  = 128'd200000000000000000000;
            code = 128'(raw >> ADC_SHIFT);
            pos  = 128'd8000000 * cal[CFG_K3] * code * code * code
                 + 128'd20000000000000000 * cal[CFG_K1] * code;
            neg  = 128'd40 * cal[CFG_K4] * code * code * code * code
                 + 128'd400000000000 * cal[CFG_K2] * code * code
                 + 128'd300000000000000000000 * cal[CFG_K0];
            if (pos >= neg) begin
                quo = (pos - neg) / den;
                exp_r.clipped = (quo > 128'd32767);
                exp_r.centi   = exp_r.clipped ? TEMP_MAX : quo[TW-1:0];
            end else begin
                mag = neg - pos;
                quo = mag / den;
                rem = mag % den;
                // Floor of a negative value moves one count further down when inexact.
                if (rem != 0) quo = quo + 128'd1;
                exp_r.clipped = (quo > 128'd32768);
                exp_r.centi   = exp_r.clipped ? TEMP_MIN : TW'(16'd0 - quo[TW-1:0]);
            end
            readings_q.push_back(exp_r);
        endfunction

        function void check_reading(logic signed [TW-1:0] centi, logic clip);
            reading_t exp_r;
            if (readings_q.size() == 0) begin
                $error("result with nothing expected: temp_centi=%0d clipped=%0b", centi, clip);
                errors++;
                return;
            end
            exp_r = readings_q.pop_front();
            if (centi !== exp_r.centi) begin
                $error("temp_centi: expected %0d, got %0d", exp_r.centi, centi);
                errors++;
            end
            if (clip !== exp_r.clipped) begin
                $error("clipped: expected %0b, got %0b", exp_r.clipped, clip);
                errors++;
            end
        endfunction

        function int pending();
            return readings_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  raw_valid;
    logic                  raw_stall;
    logic [ADC_W-1:0]      adc_raw;
    logic                  temp_valid;
    logic                  temp_stall;
    logic signed [TW-1:0]  temp_centi;
    logic                  clipped;
    logic                  cfg_we;
    logic [CFG_IW-1:0]     cfg_idx;
    logic [KW-1:0]         cfg_data;

    temp_checker sb;
    int          send_idle_pct;
    int          stall_pct;
    int          quiet_cycles;

    sensor_poly_temperature #(
        .ADC_SHIFT(ADC_SHIFT)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (raw_valid),
        .o_stall      (raw_stall),
        .i_adc_raw    (adc_raw),
        .o_valid      (temp_valid),
        .i_stall      (temp_stall),
        .o_temp_centi (temp_centi),
        .o_clipped    (clipped),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result channel at the rate of the current phase.
    always @(negedge clk) begin
        temp_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check results before noting inputs so the order within an edge never matters.
    always @(posedge clk) begin
        if (rst_n) begin
            if (temp_valid === 1'b1 && !temp_stall) sb.check_reading(temp_centi, clipped);
            if (raw_valid && raw_stall === 1'b0) sb.note_conversion(adc_raw);
        end
        if ((temp_valid === 1'b1 && !temp_stall) || (raw_valid && raw_stall === 1'b0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Abandon the run when nothing has moved for too long.
    initial begin
        @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [ADC_W-1:0] raw_of(int code);
        return ADC_W'(code << ADC_SHIFT);
    endfunction

    // Offer one item, idling first at the phase rate; hold it until accepted.
    task automatic send_conversion(logic [ADC_W-1:0] raw);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            raw_valid <= 1'b0;
            adc_raw   <= ADC_W'($urandom());
            @(negedge clk);
        end
        raw_valid <= 1'b1;
        adc_raw   <= raw;
        do @(posedge clk); while (raw_stall !== 1'b0);
    endtask

    // Drop valid and wait until every expected reading has come back.
    task automatic drain();
        @(negedge clk);
        raw_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [KW-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_cal(idx, data);
    endtask

    // Load all five words, then a write to an unused index that must change nothing.
    task automatic set_cal(cal_words_t words);
        for (int r = CFG_K4; r <= CFG_K0; r++) write_reg(CFG_IW'(r), words[r]);
        write_reg(CFG_IW'($urandom_range(CFG_SPARE, (1 << CFG_IW) - 1)), KW'($urandom()));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        cal_words_t typical;
        cal_words_t words;
        int         pick;
        sb            = new();
        send_idle_pct = 0;
        stall_pct     = 0;
        quiet_cycles  = 0;
        rst_n         = 1'b0;
        raw_valid     = 1'b0;
        adc_raw       = '0;
        temp_stall    = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        typical       = '{16'd28446, 16'd24926, 16'd36016, 16'd32791, 16'd40781};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Calibration at reset: every word zero, so every reading is zero.
        send_conversion(24'h000000);
        send_conversion(24'hFFFFFF);
        drain();

        // Typical calibration: extremes, dropped low bits, alternating patterns.
        set_cal(typical);
        send_conversion(24'h000000);
        send_conversion(24'hFFFFFF);
        send_conversion(24'h0000FF);
        send_conversion(24'h000100);
        send_conversion(24'h555555);
        send_conversion(24'hAAAAAA);
        send_conversion(24'h7FFFFF);
        send_conversion(24'h800000);
        drain();

        // Every word at its maximum.
        set_cal('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_conversion(24'h000000);
        send_conversion(24'hFFFFFF);
        drain();

        // Linear term only: top of the range exactly, one past it, and the smallest step.
        set_cal('{16'd0, 16'd0, 16'd0, 16'd10000, 16'd0});
        send_conversion(raw_of(32767));
        send_conversion(raw_of(32768));
        send_conversion(raw_of(1));
        drain();

        // Offset term only: bottom of the range reached by flooring, then just below it.
        set_cal('{16'd0, 16'd0, 16'd0, 16'd0, 16'd21845});
        send_conversion(24'h000000);
        drain();
        set_cal('{16'd0, 16'd0, 16'd0, 16'd0, 16'd21846});
        send_conversion(24'h000000);
        drain();
        // Negative one and a half counts: floor rounds away from zero.
        set_cal('{16'd0, 16'd0, 16'd0, 16'd0, 16'd1});
        send_conversion(24'h000000);
        drain();

        // Random blocks: rotate the idle pattern and the kind of calibration.
        for (int blk = 0; blk < BLOCKS; blk++) begin
            case (blk % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 45; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            case ((blk + blk / 4) % 4)
                0: foreach (words[r]) words[r] = typical[r] + KW'($urandom_range(2047)) - 16'd1024;
                1: foreach (words[r]) words[r] = KW'($urandom());
                2: begin
                    foreach (words[r]) words[r] = '0;
                    words[$urandom_range(CFG_K4, CFG_K0)] = KW'($urandom());
                end
                default: foreach (words[r]) words[r] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            endcase
            set_cal(words);
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                pick = $urandom_range(9);
                case (pick)
                    0: send_conversion(24'h000000);
                    1: send_conversion(24'hFFFFFF);
                    2: send_conversion(ADC_W'($urandom()) | 24'hFF0000);
                    3: send_conversion(ADC_W'($urandom()) & 24'h00FFFF);
                    default: send_conversion(ADC_W'($urandom()));
                endcase
            end
            drain();
        end

        // Let any stray result surface before judging the run.
        repeat (DRAIN_TAIL) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
